@@ src/vplc_pkg.sv @@
package vplc_pkg;

  // fixed field widths
  localparam int TARGET_W = 16;
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 15;
  localparam int FILT_W   = 18;
  localparam int INTEG_W  = 16;
  localparam int DRIVE_W  = 32;

  localparam int ENCODER_BITS_DEF = 16;

  // gains carry eight fraction bits
  localparam int GAIN_FRAC = 8;

  // low-pass weights: new = (3*err + 7*last) / 10
  localparam int DIV_BY       = 10;
  localparam int FILT_SAT_MAG = DIV_BY * (2 ** (FILT_W - 1));
  // magnitudes below the saturation point fit in this many bits
  localparam int MAG_W        = $clog2(FILT_SAT_MAG);
  // divide by ten as a multiply by ceil(2^24 / 10) and a shift by 24
  localparam int RECIP_SH     = 24;
  localparam int DIV_RECIP    = (2 ** RECIP_SH + DIV_BY - 1) / DIV_BY;

  localparam int LIMIT_RESET = 10000;

  // apb register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_INTEG_LIM  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [LIMIT_W-1:0] integral_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FILT,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

@@ src/vplc_regs.sv @@
module vplc_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vplc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [vplc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [vplc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output vplc_pkg::cfg_t                     cfg_o
);
  import vplc_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.integral_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[GAIN_W-1:0];
        REG_INTEG_LIM:  cfg_q.integral_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:
        prdata = {{(APB_DATA_W-GAIN_W){cfg_q.prop_gain[GAIN_W-1]}}, cfg_q.prop_gain};
      REG_INTEG_GAIN:
        prdata = {{(APB_DATA_W-GAIN_W){cfg_q.integ_gain[GAIN_W-1]}}, cfg_q.integ_gain};
      REG_INTEG_LIM:
        prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_q.integral_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ src/velocity_pi_lowpass_controller_core.sv @@
// speed loop pi controller with a low-pass filtered error and a clamped integral
//
// input channel (in_valid_i / in_ready_o) takes one item: speed setpoint and the
// two encoder counts; output channel (out_valid_o / out_ready_i) returns one
// drive value per item. gains and the integral limit sit behind the apb port.
// the user must write them only in idle; the block itself does not enforce it.
//
// an item is taken only in idle; it then steps through prep, divide, filter,
// integral, both products, sum and output, which loads the output register;
// divide is skipped when the filtered error saturates. one shared multiplier
// does the divide by ten of the filter as a reciprocal multiply, then the
// proportional and the integral product, one step each. the next item is
// taken only once the block is back in idle after the output step.
//
// a finished result waits in the output register; the next item is accepted
// meanwhile, and its result is held in the last step until the receiver has
// taken the previous one. reset clears the filter and integral state, loads the
// default gains of zero and a limit of 10000, and empties the output register.
module velocity_pi_lowpass_controller_core #(
  parameter int ENCODER_BITS = vplc_pkg::ENCODER_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [vplc_pkg::TARGET_W-1:0]  speed_setpoint_i,
  input  logic signed [ENCODER_BITS-1:0]        left_count_i,
  input  logic signed [ENCODER_BITS-1:0]        right_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [vplc_pkg::DRIVE_W-1:0]   drive_out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vplc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [vplc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [vplc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import vplc_pkg::*;

  localparam int IN_W   = (ENCODER_BITS > TARGET_W) ? ENCODER_BITS : TARGET_W;
  localparam int ERR_W  = IN_W + 2;
  localparam int NUM_W  = ((ERR_W + 2 > FILT_W + 3) ? ERR_W + 2 : FILT_W + 3) + 1;
  localparam int ISUM_W = FILT_W + 1;
  localparam int MA_W   = GAIN_W + 1;
  localparam int MB_W   = MAG_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = GAIN_W + FILT_W + 1;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic signed [ERR_W-1:0]   err_in, err_q;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          mag;
  logic                      sat_in;
  logic                      neg_q, sat_q;
  logic [MAG_W-1:0]          mag_q;
  logic signed [FILT_W-1:0]  quot_s, filt_new, filt_q;
  logic signed [INTEG_W-1:0] integ_q, integ_new, integ_lim;
  logic signed [ISUM_W-1:0]  isum, lim_s;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p, prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_adj, acc_shr;
  logic [ACC_W-DRIVE_W:0]    acc_top;
  logic signed [DRIVE_W-1:0] drive_new, out_q;
  logic                      out_valid_q, out_load;

  vplc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_out_o = out_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign err_in = ERR_W'(left_count_i) + ERR_W'(right_count_i) - ERR_W'(speed_setpoint_i);

  // 3*err + 7*last
  assign num = (NUM_W'(err_q) <<< 1) + NUM_W'(err_q)
             + (NUM_W'(filt_q) <<< 3) - NUM_W'(filt_q);
  assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign sat_in = (mag >= NUM_W'(FILT_SAT_MAG));

  // quotient of the reciprocal multiply
  assign quot_s = $signed(prod_q[RECIP_SH+FILT_W-1:RECIP_SH]);
  always_comb begin
    if (sat_q) begin
      filt_new = neg_q ? $signed({1'b1, {(FILT_W-1){1'b0}}})
                       : $signed({1'b0, {(FILT_W-1){1'b1}}});
    end else begin
      filt_new = neg_q ? -quot_s : quot_s;
    end
  end

  assign integ_lim = $signed({1'b0, cfg.integral_limit});
  assign lim_s     = ISUM_W'(integ_lim);
  assign isum      = ISUM_W'(integ_q) + ISUM_W'(filt_q);
  always_comb begin
    if (isum > lim_s) begin
      integ_new = integ_lim;
    end else if (isum < -lim_s) begin
      integ_new = -integ_lim;
    end else begin
      integ_new = INTEG_W'(isum);
    end
  end

  // shared multiplier
  always_comb begin
    if (state_q == ST_MUL_P) begin
      mul_a = $signed({cfg.prop_gain[GAIN_W-1], cfg.prop_gain});
      mul_b = MB_W'(filt_q);
    end else if (state_q == ST_MUL_I) begin
      mul_a = $signed({cfg.integ_gain[GAIN_W-1], cfg.integ_gain});
      mul_b = MB_W'(integ_q);
    end else begin
      // reciprocal of ten, exact for every magnitude below the saturation point
      mul_a = MA_W'(DIV_RECIP);
      mul_b = $signed({1'b0, mag_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // drop the fraction toward zero, then saturate
  assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << GAIN_FRAC) - 1) : ACC_W'(0));
  assign acc_shr = acc_adj >>> GAIN_FRAC;
  assign acc_top = acc_shr[ACC_W-1:DRIVE_W-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      drive_new = acc_shr[DRIVE_W-1:0];
    end else if (acc_shr[ACC_W-1]) begin
      drive_new = $signed({1'b1, {(DRIVE_W-1){1'b0}}});
    end else begin
      drive_new = $signed({1'b0, {(DRIVE_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = sat_in ? ST_FILT : ST_DIV;
      ST_DIV:   state_d = ST_FILT;
      ST_FILT:  state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // filter and integral state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      integ_q <= '0;
    end else begin
      if (state_q == ST_FILT) filt_q <= filt_new;
      if (state_q == ST_INTEG) integ_q <= integ_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) err_q <= err_in;
    if (out_load) out_q <= drive_new;
    unique case (state_q)
      ST_PREP: begin
        neg_q <= num[NUM_W-1];
        sat_q <= sat_in;
        mag_q <= mag[MAG_W-1:0];
      end
      ST_DIV:   prod_q <= mul_p;
      ST_MUL_P: prod_q <= mul_p;
      ST_MUL_I: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= mul_p;
      end
      ST_SUM:   acc_q <= acc_q + ACC_W'(prod_q);
      default: ;
    endcase
  end

  a_integral_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_P) |-> ((integ_q <= integ_lim) && (integ_q >= -integ_lim)))
    else $error("integral outside its limit");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("result not presented after final step");

  a_item_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_PREP))
    else $error("accepted item did not start");

  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(drive_out_o)))
    else $error("waiting result changed");

endmodule
